### hw/rtl/s2d3_pkg.sv
// Shared types, codes, saturation helpers and the microprogram of the space-to-depth generator.
package s2d3_pkg;

    // Configuration register indexes and widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_DEPTH     = 3'd4;

    localparam logic [12:0] RST_CHANNEL_COUNT = 13'd1;
    localparam logic [4:0]  RST_SCALE_FACTOR  = 5'd2;
    localparam logic [12:0] RST_OUT_SIZE      = 13'd1;

    localparam logic [12:0] SIZE_MAX  = 13'd4096;
    localparam logic [4:0]  SCALE_MAX = 5'd16;

    // Micro-operations of the shared arithmetic unit.
    localparam logic [1:0] OP_NOP  = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_MUL  = 2'd2;
    localparam logic [1:0] OP_ADD  = 2'd3;

    // Multiplier factor selects.
    localparam logic [2:0] F_S  = 3'd0;
    localparam logic [2:0] F_C  = 3'd1;
    localparam logic [2:0] F_OW = 3'd2;
    localparam logic [2:0] F_OH = 3'd3;
    localparam logic [2:0] F_OD = 3'd4;

    // Addend selects.
    localparam logic [2:0] A_PX    = 3'd0;
    localparam logic [2:0] A_PY    = 3'd1;
    localparam logic [2:0] A_PZ    = 3'd2;
    localparam logic [2:0] A_SZ    = 3'd3;
    localparam logic [2:0] A_SY    = 3'd4;
    localparam logic [2:0] A_SB    = 3'd5;
    localparam logic [2:0] A_DB    = 3'd6;
    localparam logic [2:0] A_BATCH = 3'd7;

    // Where the result of a step is captured besides the accumulator.
    localparam logic [1:0] CAP_NONE = 2'd0;
    localparam logic [1:0] CAP_SRC  = 2'd1;
    localparam logic [1:0] CAP_DST  = 2'd2;
    localparam logic [1:0] CAP_BASE = 2'd3;

    // Sequencing codes.
    localparam logic [1:0] SEQ_NEXT     = 2'd0;
    localparam logic [1:0] SEQ_DISPATCH = 2'd1;
    localparam logic [1:0] SEQ_EMIT     = 2'd2;
    localparam logic [1:0] SEQ_OPEN     = 2'd3;

    localparam int UPC_W = 6;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t PC_ENTRY = 6'd0;
    localparam upc_t PC_FRAME = 6'd26;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] fsel;
        logic [2:0] asel;
        logic [1:0] cap;
        logic [1:0] seq;
        upc_t       target;
    } uword_t;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] fsel;
        logic [2:0] asel;
        logic [1:0] cap;
        logic       open_frame;
        logic       emit;
    } dp_ctrl_t;

    // Configuration after saturation into its legal range.
    typedef struct packed {
        logic [12:0] chan;
        logic [4:0]  scale;
        logic [12:0] width;
        logic [12:0] height;
        logic [12:0] depth;
    } cfg_t;

    function automatic logic [12:0] sat_size(logic [12:0] v);
        if (v == 13'd0) begin
            return 13'd1;
        end
        return (v > SIZE_MAX) ? SIZE_MAX : v;
    endfunction

    function automatic logic [4:0] sat_scale(logic [4:0] v);
        if (v == 5'd0) begin
            return 5'd1;
        end
        return (v > SCALE_MAX) ? SCALE_MAX : v;
    endfunction

    function automatic uword_t uw(logic [1:0] op, logic [2:0] fsel, logic [2:0] asel,
                                  logic [1:0] cap, logic [1:0] seq, upc_t target);
        uword_t w;
        w.op     = op;
        w.fsel   = fsel;
        w.asel   = asel;
        w.cap    = cap;
        w.seq    = seq;
        w.target = target;
        return w;
    endfunction

    // Microprogram. Source index by Horner's rule:
    //   ((((pz*s + sz)*oh + py)*s + sy)*ow + px)*s*c + source_base
    // Destination index:
    //   ((((pz*oh + py)*ow + px)*s + sz)*s + sy)*s*c + dest_base
    // Frame base: batch*c*s*s*s*ow*oh*od
    function automatic uword_t ucode_rom(upc_t pc);
        uword_t w;
        unique case (pc)
            6'd0:  w = uw(OP_NOP,  F_S,  A_PX,    CAP_NONE, SEQ_DISPATCH, PC_FRAME);
            // source offset
            6'd1:  w = uw(OP_LOAD, F_S,  A_PZ,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd2:  w = uw(OP_MUL,  F_S,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd3:  w = uw(OP_ADD,  F_S,  A_SZ,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd4:  w = uw(OP_MUL,  F_OH, A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd5:  w = uw(OP_ADD,  F_S,  A_PY,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd6:  w = uw(OP_MUL,  F_S,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd7:  w = uw(OP_ADD,  F_S,  A_SY,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd8:  w = uw(OP_MUL,  F_OW, A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd9:  w = uw(OP_ADD,  F_S,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd10: w = uw(OP_MUL,  F_S,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd11: w = uw(OP_MUL,  F_C,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd12: w = uw(OP_ADD,  F_S,  A_SB,    CAP_SRC,  SEQ_NEXT, PC_ENTRY);
            // destination offset
            6'd13: w = uw(OP_LOAD, F_S,  A_PZ,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd14: w = uw(OP_MUL,  F_OH, A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd15: w = uw(OP_ADD,  F_S,  A_PY,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd16: w = uw(OP_MUL,  F_OW, A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd17: w = uw(OP_ADD,  F_S,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd18: w = uw(OP_MUL,  F_S,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd19: w = uw(OP_ADD,  F_S,  A_SZ,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd20: w = uw(OP_MUL,  F_S,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd21: w = uw(OP_ADD,  F_S,  A_SY,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd22: w = uw(OP_MUL,  F_S,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd23: w = uw(OP_MUL,  F_C,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd24: w = uw(OP_ADD,  F_S,  A_DB,    CAP_DST,  SEQ_NEXT, PC_ENTRY);
            6'd25: w = uw(OP_NOP,  F_S,  A_PX,    CAP_NONE, SEQ_EMIT, PC_ENTRY);
            // frame base on restart
            6'd26: w = uw(OP_LOAD, F_S,  A_BATCH, CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd27: w = uw(OP_MUL,  F_C,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd28: w = uw(OP_MUL,  F_S,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd29: w = uw(OP_MUL,  F_S,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd30: w = uw(OP_MUL,  F_S,  A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd31: w = uw(OP_MUL,  F_OW, A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd32: w = uw(OP_MUL,  F_OH, A_PX,    CAP_NONE, SEQ_NEXT, PC_ENTRY);
            6'd33: w = uw(OP_MUL,  F_OD, A_PX,    CAP_BASE, SEQ_OPEN, PC_ENTRY);
            default: w = uw(OP_NOP, F_S, A_PX,    CAP_NONE, SEQ_OPEN, PC_ENTRY);
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/s2d3_sequencer.sv
// Microprogram counter, control store fetch and branch logic.
module s2d3_sequencer
    import s2d3_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_fire,
    input  logic     in_restart,
    input  logic     frame_active,
    input  logic     out_free,
    output logic     in_ready,
    output dp_ctrl_t ctrl
);

    upc_t   upc_reg;
    upc_t   upc_next;
    uword_t word;

    assign word     = ucode_rom(upc_reg);
    assign in_ready = (word.seq == SEQ_DISPATCH);

    always_comb begin
        upc_next        = upc_reg + upc_t'(1);
        ctrl.op         = word.op;
        ctrl.fsel       = word.fsel;
        ctrl.asel       = word.asel;
        ctrl.cap        = word.cap;
        ctrl.open_frame = 1'b0;
        ctrl.emit       = 1'b0;
        unique case (word.seq)
            SEQ_NEXT: begin
                upc_next = upc_reg + upc_t'(1);
            end
            SEQ_DISPATCH: begin
                if (in_fire && in_restart) begin
                    upc_next = word.target;
                end else if (in_fire && frame_active) begin
                    upc_next = upc_reg + upc_t'(1);
                end else begin
                    upc_next = upc_reg;
                end
            end
            SEQ_EMIT: begin
                if (out_free) begin
                    upc_next  = word.target;
                    ctrl.emit = 1'b1;
                end else begin
                    upc_next = upc_reg;
                end
            end
            SEQ_OPEN: begin
                upc_next        = word.target;
                ctrl.open_frame = (word.cap == CAP_BASE);
            end
            default: begin
                upc_next = PC_ENTRY;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= PC_ENTRY;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

### hw/rtl/s2d3_datapath.sv
// Shared multiply/add unit, run counters, frame bases and offset capture registers.
module s2d3_datapath
    import s2d3_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_ctrl_t    ctrl,
    input  cfg_t        cfg,
    input  logic        batch_load,
    input  logic [15:0] batch_in,
    output logic        frame_active,
    output logic [31:0] src_offset,
    output logic [31:0] dst_offset,
    output logic [16:0] run_length,
    output logic        last_run
);

    logic [OFFSET_BITS-1:0]  acc_reg;
    logic [OFFSET_BITS-1:0]  acc_next;
    logic [OFFSET_BITS-1:0]  src_reg;
    logic [OFFSET_BITS-1:0]  dst_reg;
    logic [OFFSET_BITS-1:0]  source_base_reg;
    logic [OFFSET_BITS-1:0]  dest_base_reg;
    logic [OFFSET_BITS-1:0]  addend;
    logic [OFFSET_BITS-1:0]  product;
    logic [12:0]             factor;
    logic [15:0]             batch_reg;
    logic [11:0]             pos_x_reg, pos_y_reg, pos_z_reg;
    logic [3:0]              sub_z_reg, sub_y_reg;
    logic                    active_reg;
    logic                    wky, wkz, wx, wy, wz;

    always_comb begin
        unique case (ctrl.fsel)
            F_S:     factor = 13'(cfg.scale);
            F_C:     factor = cfg.chan;
            F_OW:    factor = cfg.width;
            F_OH:    factor = cfg.height;
            F_OD:    factor = cfg.depth;
            default: factor = 13'd1;
        endcase
    end

    always_comb begin
        unique case (ctrl.asel)
            A_PX:    addend = OFFSET_BITS'(pos_x_reg);
            A_PY:    addend = OFFSET_BITS'(pos_y_reg);
            A_PZ:    addend = OFFSET_BITS'(pos_z_reg);
            A_SZ:    addend = OFFSET_BITS'(sub_z_reg);
            A_SY:    addend = OFFSET_BITS'(sub_y_reg);
            A_SB:    addend = source_base_reg;
            A_DB:    addend = dest_base_reg;
            A_BATCH: addend = OFFSET_BITS'(batch_reg);
            default: addend = '0;
        endcase
    end

    // Offsets are kept modulo 2^OFFSET_BITS, so only the low product bits matter.
    assign product = acc_reg * OFFSET_BITS'(factor);

    always_comb begin
        unique case (ctrl.op)
            OP_NOP:  acc_next = acc_reg;
            OP_LOAD: acc_next = addend;
            OP_MUL:  acc_next = product;
            OP_ADD:  acc_next = acc_reg + addend;
            default: acc_next = acc_reg;
        endcase
    end

    // A counter wraps once it has reached its limit minus one.
    assign wky = (5'(sub_y_reg) + 5'd1) >= cfg.scale;
    assign wkz = (5'(sub_z_reg) + 5'd1) >= cfg.scale;
    assign wx  = (13'(pos_x_reg) + 13'd1) >= cfg.width;
    assign wy  = (13'(pos_y_reg) + 13'd1) >= cfg.height;
    assign wz  = (13'(pos_z_reg) + 13'd1) >= cfg.depth;
    assign last_run = wky && wkz && wx && wy && wz;

    assign run_length   = 17'(cfg.scale) * cfg.chan;
    assign src_offset   = 32'(src_reg);
    assign dst_offset   = 32'(dst_reg);
    assign frame_active = active_reg;

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (batch_load) begin
            batch_reg <= batch_in;
        end
        if (ctrl.cap == CAP_SRC) begin
            src_reg <= acc_next;
        end
        if (ctrl.cap == CAP_DST) begin
            dst_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            pos_z_reg       <= '0;
            sub_z_reg       <= '0;
            sub_y_reg       <= '0;
            source_base_reg <= '0;
            dest_base_reg   <= '0;
        end else if (ctrl.open_frame) begin
            active_reg      <= 1'b1;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            pos_z_reg       <= '0;
            sub_z_reg       <= '0;
            sub_y_reg       <= '0;
            source_base_reg <= acc_next;
            dest_base_reg   <= acc_next;
        end else if (ctrl.emit) begin
            priority if (last_run) begin
                active_reg <= 1'b0;
                pos_x_reg  <= '0;
                pos_y_reg  <= '0;
                pos_z_reg  <= '0;
                sub_z_reg  <= '0;
                sub_y_reg  <= '0;
            end else if (!wky) begin
                sub_y_reg <= sub_y_reg + 4'd1;
            end else if (!wkz) begin
                sub_y_reg <= '0;
                sub_z_reg <= sub_z_reg + 4'd1;
            end else if (!wx) begin
                sub_y_reg <= '0;
                sub_z_reg <= '0;
                pos_x_reg <= pos_x_reg + 12'd1;
            end else if (!wy) begin
                sub_y_reg <= '0;
                sub_z_reg <= '0;
                pos_x_reg <= '0;
                pos_y_reg <= pos_y_reg + 12'd1;
            end else begin
                sub_y_reg <= '0;
                sub_z_reg <= '0;
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= pos_z_reg + 12'd1;
            end
        end
    end

endmodule

### hw/rtl/space_to_depth_3d_address_gen.sv
// Top level of the 3D space-to-depth copy-descriptor generator.
//
// This block issues copy descriptors for a 3D space-to-depth reorder of one batch entry.
// An input item with tuser set (restart) opens a frame for the batch index in tdata and
// yields no result; each following item with tuser clear yields one descriptor: the source
// and destination element offsets of a contiguous run of scale times channels floats, with
// tlast marking the final run of the frame. Runs are visited from output z, y and x down to
// the block z and y offsets. Items that advance while no frame is open are taken and
// dropped. All offsets are computed by one shared multiply/add unit under a microprogram of
// 34 steps, one operation per cycle while no step waits on the input or the output: a
// restart item runs the frame-base steps, an advancing item runs the offset steps (the
// result enters the output register in the last of them), and an advance outside a
// frame is taken back to back. A result waiting on the output stalls only the final step
// of the next item. Offsets are formed modulo 2^OFFSET_BITS and presented as their low 32
// bits. Configuration writes take effect at once and should only be made while the block
// is idle; out-of-range values are saturated into their legal range when used.
module space_to_depth_3d_address_gen
    import s2d3_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] batch_index
    input  logic                  s_tuser,   // [0] restart

    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [87:0]           m_tdata,   // [31:0] source_offset, [63:32] dest_offset,
                                             // [80:64] run_length, [87:81] zero
    output logic                  m_tlast    // last_in_frame
);

    // Raw configuration registers, saturated on use.
    logic [12:0] channel_count_reg;
    logic [4:0]  scale_factor_reg;
    logic [12:0] out_width_reg;
    logic [12:0] out_height_reg;
    logic [12:0] out_depth_reg;
    cfg_t        cfg;

    dp_ctrl_t    ctrl;
    logic        in_fire;
    logic        in_ready;
    logic        out_free;
    logic        frame_active;
    logic [31:0] src_offset;
    logic [31:0] dst_offset;
    logic [16:0] run_length;
    logic        last_run;

    logic        m_tvalid_reg;
    logic [31:0] m_src_reg;
    logic [31:0] m_dst_reg;
    logic [16:0] m_len_reg;
    logic        m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= RST_CHANNEL_COUNT;
            scale_factor_reg  <= RST_SCALE_FACTOR;
            out_width_reg     <= RST_OUT_SIZE;
            out_height_reg    <= RST_OUT_SIZE;
            out_depth_reg     <= RST_OUT_SIZE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_wr_data;
                REG_SCALE_FACTOR:  scale_factor_reg  <= cfg_wr_data[4:0];
                REG_OUT_WIDTH:     out_width_reg     <= cfg_wr_data;
                REG_OUT_HEIGHT:    out_height_reg    <= cfg_wr_data;
                REG_OUT_DEPTH:     out_depth_reg     <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg.chan   = sat_size(channel_count_reg);
    assign cfg.scale  = sat_scale(scale_factor_reg);
    assign cfg.width  = sat_size(out_width_reg);
    assign cfg.height = sat_size(out_height_reg);
    assign cfg.depth  = sat_size(out_depth_reg);

    assign s_tready = in_ready;
    assign in_fire  = s_tvalid && in_ready;

    // The output register frees up in the same cycle as its result is taken.
    assign out_free = !m_tvalid_reg || m_tready;

    s2d3_sequencer u_sequencer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .in_restart   (s_tuser),
        .frame_active (frame_active),
        .out_free     (out_free),
        .in_ready     (in_ready),
        .ctrl         (ctrl)
    );

    s2d3_datapath #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .cfg          (cfg),
        .batch_load   (in_fire),
        .batch_in     (s_tdata),
        .frame_active (frame_active),
        .src_offset   (src_offset),
        .dst_offset   (dst_offset),
        .run_length   (run_length),
        .last_run     (last_run)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            m_src_reg  <= src_offset;
            m_dst_reg  <= dst_offset;
            m_len_reg  <= run_length;
            m_last_reg <= last_run;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_len_reg, m_dst_reg, m_src_reg};
    assign m_tlast  = m_last_reg;

endmodule

### hw/rtl/s2d3_checker.sv
// Port-level checks of the space-to-depth generator and their binding to the top level.
module s2d3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        m_tlast
);

    // A restart occupies the block, so no further item is taken in the next cycle.
    a_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> !s_tready)
        else $error("input taken directly after a restart item");

    // No item produces its result in the cycle after it is taken.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after an item was taken");

    // Every run carries at least one element.
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[80:64] != 17'd0))
        else $error("run length of zero");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind space_to_depth_3d_address_gen s2d3_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### test/tb_space_to_depth_3d_address_gen.sv
// Self-checking testbench for the 3D space-to-depth copy-descriptor generator.
module tb_space_to_depth_3d_address_gen;
    timeunit 1ns;
    timeprecision 1ps;

    import s2d3_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    // This pause comfortably covers a restart or an advance that is still in flight but
    // produces no descriptor.
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    // Longest quiet stretch of a correct run is the receiver hold-off plus one item;
    // the limit is several times that.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int DIRECTED_ROWS  = 25;
    localparam int MAX_PRINTED    = 40;

    // Register indexes past the last real register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_OUT_DEPTH + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    // One copy descriptor as it leaves the block.
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [16:0] len;
        logic        last;
    } run_desc_t;

    typedef enum logic {ROW_ITEM, ROW_SETTING} row_kind_e;

    // One row of the directed table: either an input item or a full register setting.
    // Where checked is set, the descriptor (or its absence) is typed in by hand.
    typedef struct packed {
        row_kind_e   kind;
        logic        restart;
        logic [15:0] batch;
        logic        checked;
        logic        yields;
        run_desc_t   want;
        logic [12:0] cfg_c;
        logic [12:0] cfg_s;
        logic [12:0] cfg_w;
        logic [12:0] cfg_h;
        logic [12:0] cfg_d;
    } step_row_t;

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH
    } idle_phase_e;

    // Clock and reset.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Block inputs, all known from time zero.
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic [15:0]           s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tready    = 1'b0;

    logic                  s_tready;
    logic                  m_tvalid;
    logic [87:0]           m_tdata;
    logic                  m_tlast;

    space_to_depth_3d_address_gen u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),   // [15:0] batch_index
        .s_tuser     (s_tuser),   // [0] restart
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),   // [31:0] source_offset, [63:32] dest_offset,
                                  // [80:64] run_length, [87:81] zero
        .m_tlast     (m_tlast)    // last_in_frame
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and the frame walk.
    // ------------------------------------------------------------------
    logic [12:0] c_chan   = RST_CHANNEL_COUNT;
    logic [4:0]  c_scale  = RST_SCALE_FACTOR;
    logic [12:0] c_width  = RST_OUT_SIZE;
    logic [12:0] c_height = RST_OUT_SIZE;
    logic [12:0] c_depth  = RST_OUT_SIZE;

    logic [11:0] px = '0, py = '0, pz = '0;
    logic [3:0]  bz = '0, by = '0;
    logic [31:0] src_base = '0, dst_base = '0;
    logic        in_frame = 1'b0;

    // Descriptors predicted but not yet seen on the output, oldest first.
    run_desc_t runs_due[$];
    run_desc_t due;

    int errors          = 0;
    int items_sent      = 0;
    int restarts_sent   = 0;
    int runs_checked    = 0;
    int frames_closed   = 0;
    int settings_written = 0;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    int unsigned hold_req  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned quiet     = 0;

    // A register value of zero reads as one and anything above the ceiling as the ceiling.
    function automatic logic [63:0] clamp_field(logic [12:0] v, logic [12:0] hi);
        if (v == '0) begin
            return 64'd1;
        end
        return (v > hi) ? {51'd0, hi} : {51'd0, v};
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (errors < MAX_PRINTED) begin
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        end
        errors++;
    endtask

    // Advances the frame walk for one accepted item and returns the descriptor it yields.
    task automatic next_run_desc(input logic restart, input logic [15:0] batch,
                                 output logic yields, output run_desc_t d);
        logic [63:0] c, s, ow, oh, od, iw, ih, outc, len, base, src, dst;
        logic        wrap_by, wrap_bz, wrap_x, wrap_y, wrap_z, last;
        c    = clamp_field(c_chan, SIZE_MAX);
        s    = clamp_field({8'd0, c_scale}, {8'd0, SCALE_MAX});
        ow   = clamp_field(c_width, SIZE_MAX);
        oh   = clamp_field(c_height, SIZE_MAX);
        od   = clamp_field(c_depth, SIZE_MAX);
        iw   = ow * s;
        ih   = oh * s;
        outc = c * s * s * s;
        len  = s * c;
        yields = 1'b0;
        d      = '0;
        if (restart) begin
            // A restart abandons any open frame and starts the walk afresh.
            base     = outc * ow * oh * od * {48'd0, batch};
            src_base = base[31:0];
            dst_base = base[31:0];
            {px, py, pz, bz, by} = '0;
            in_frame = 1'b1;
        end else if (in_frame) begin
            src = src_base + (((pz * s + bz) * ih * iw + (py * s + by) * iw + px * s) * c);
            dst = dst_base + (px + py * ow + pz * ow * oh) * outc + (bz * s + by) * len;
            // Counters wrap once they have reached or passed their limit minus one, which matters
            // when the registers shrink while a frame is open.
            wrap_by = (by + 64'd1) >= s;
            wrap_bz = (bz + 64'd1) >= s;
            wrap_x  = (px + 64'd1) >= ow;
            wrap_y  = (py + 64'd1) >= oh;
            wrap_z  = (pz + 64'd1) >= od;
            last    = wrap_by && wrap_bz && wrap_x && wrap_y && wrap_z;
            d.src   = src[31:0];
            d.dst   = dst[31:0];
            d.len   = len[16:0];
            d.last  = last;
            yields  = 1'b1;
            if (last) begin
                {px, py, pz, bz, by} = '0;
                in_frame = 1'b0;
            end else if (!wrap_by) begin
                by++;
            end else begin
                by = '0;
                if (!wrap_bz) begin
                    bz++;
                end else begin
                    bz = '0;
                    if (!wrap_x) begin
                        px++;
                    end else begin
                        px = '0;
                        if (!wrap_y) begin
                            py++;
                        end else begin
                            py = '0;
                            pz++;
                        end
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Table helpers.
    // ------------------------------------------------------------------
    function automatic step_row_t plain_item(logic restart, logic [15:0] batch);
        step_row_t r = '0;
        r.kind    = ROW_ITEM;
        r.restart = restart;
        r.batch   = batch;
        return r;
    endfunction

    // An item known to yield nothing: a restart, or an advance outside a frame.
    function automatic step_row_t silent_item(logic restart, logic [15:0] batch);
        step_row_t r = plain_item(restart, batch);
        r.checked = 1'b1;
        return r;
    endfunction

    function automatic step_row_t known_run(logic [31:0] src, logic [31:0] dst,
                                            logic [16:0] len, logic last);
        step_row_t r = plain_item(1'b0, 16'h0000);
        r.checked = 1'b1;
        r.yields  = 1'b1;
        r.want    = '{src: src, dst: dst, len: len, last: last};
        return r;
    endfunction

    function automatic step_row_t setting(logic [12:0] c, logic [12:0] s, logic [12:0] w,
                                          logic [12:0] h, logic [12:0] d);
        step_row_t r = '0;
        r.kind  = ROW_SETTING;
        r.cfg_c = c;
        r.cfg_s = s;
        r.cfg_w = w;
        r.cfg_h = h;
        r.cfg_d = d;
        return r;
    endfunction

    // Sizes are mostly tiny so that frames close often; now and then anything the
    // register holds, including zero and values above the ceiling.
    function automatic logic [12:0] pick_size();
        int r = $urandom_range(0, 99);
        if (r < 75) begin
            return 13'($urandom_range(1, 3));
        end else if (r < 90) begin
            return 13'($urandom_range(4, 12));
        end
        return 13'($urandom_range(0, 8191));
    endfunction

    // The scale register keeps only five bits; the rest of the write data is junk.
    function automatic logic [12:0] pick_scale();
        logic [12:0] v = 13'($urandom_range(0, 8191));
        int          r = $urandom_range(0, 99);
        if (r < 80) begin
            v[4:0] = 5'($urandom_range(1, 4));
        end else if (r < 90) begin
            v[4:0] = 5'($urandom_range(5, 16));
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks. Every one of them starts in the time step of a rising edge.
    // ------------------------------------------------------------------
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (idx)
            REG_CHANNEL_COUNT: c_chan   = val;
            REG_SCALE_FACTOR:  c_scale  = val[4:0];
            REG_OUT_WIDTH:     c_width  = val;
            REG_OUT_HEIGHT:    c_height = val;
            REG_OUT_DEPTH:     c_depth  = val;
            default: ;
        endcase
    endtask

    // Writes all five registers and one spare index, then releases the write enable.
    task automatic apply_config(input logic [12:0] c, input logic [12:0] s,
                                input logic [12:0] w, input logic [12:0] h,
                                input logic [12:0] d);
        write_register(REG_CHANNEL_COUNT, c);
        write_register(REG_SCALE_FACTOR, s);
        write_register(REG_OUT_WIDTH, w);
        write_register(REG_OUT_HEIGHT, h);
        write_register(REG_OUT_DEPTH, d);
        write_register(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                       CFG_DATA_W'($urandom_range(0, 8191)));
        cfg_wr_en <= 1'b0;
        settings_written++;
    endtask

    // Lets the block run dry: every predicted descriptor has arrived and any item
    // still in flight without a descriptor has had time to finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (runs_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Offers one item, possibly after a random gap, and predicts its descriptor once the
    // handshake completes. tvalid is left high so that items can follow back to back.
    task automatic send_item(input step_row_t row, output logic produced);
        run_desc_t d;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom_range(0, 65535));
            s_tuser  <= 1'($urandom_range(0, 1));
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.restart;
        s_tdata  <= row.batch;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (row.restart) begin
            restarts_sent++;
        end
        next_run_desc(row.restart, row.batch, produced, d);
        if (row.checked) begin
            produced = row.yields;
            d        = row.want;
        end
        if (produced) begin
            runs_due.push_back(d);
        end
    endtask

    task automatic set_phase(input idle_phase_e ph);
        idle_pct  = (ph == PH_SENDER_IDLE) ? 50 : (ph == PH_BOTH) ? 28 : 0;
        stall_pct <= (ph == PH_RECEIVER_STALL) ? 50 : (ph == PH_BOTH) ? 28 : 0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: checks every accepted descriptor against the oldest prediction and
    // drives tready, including one long hold-off requested by the stimulus.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (runs_due.size() == 0) begin
                note_mismatch("descriptor with none expected", m_tdata[31:0], '0);
            end else begin
                due = runs_due.pop_front();
                if (m_tdata[31:0] != due.src) begin
                    note_mismatch("source_offset", m_tdata[31:0], due.src);
                end
                if (m_tdata[63:32] != due.dst) begin
                    note_mismatch("dest_offset", m_tdata[63:32], due.dst);
                end
                if (m_tdata[80:64] != due.len) begin
                    note_mismatch("run_length", 32'(m_tdata[80:64]), 32'(due.len));
                end
                if (m_tlast != due.last) begin
                    note_mismatch("last_in_frame", 32'(m_tlast), 32'(due.last));
                end
                if (m_tdata[87:81] != '0) begin
                    note_mismatch("tdata padding", 32'(m_tdata[87:81]), '0);
                end
                runs_checked++;
                if (due.last) begin
                    frames_closed++;
                end
            end
        end
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: ends the run if nothing at all is accepted for too long.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    step_row_t directed_steps [0:DIRECTED_ROWS-1];

    initial begin
        step_row_t   row;
        logic        produced;
        logic        held;
        int          rand_items;
        int          seq_no;
        int          runs_left;
        logic [63:0] frame_runs;
        logic [63:0] sc;

        // With the reset setting (one channel, scale two, a single output position)
        // a frame is four runs of two floats each, and a batch moves the base by eight.
        directed_steps = '{
            silent_item(1'b0, 16'h0000),             // advance with no frame open
            silent_item(1'b1, 16'h0000),             // restart yields nothing
            known_run(32'd0, 32'd0, 17'd2, 1'b0),
            known_run(32'd2, 32'd2, 17'd2, 1'b0),
            known_run(32'd4, 32'd4, 17'd2, 1'b0),
            known_run(32'd6, 32'd6, 17'd2, 1'b1),    // frame closes
            silent_item(1'b0, 16'hFFFF),             // idle again after the last run
            silent_item(1'b1, 16'hFFFF),             // largest batch index
            known_run(32'h0007_FFF8, 32'h0007_FFF8, 17'd2, 1'b0),
            silent_item(1'b1, 16'h0001),             // restart abandons the open frame
            known_run(32'd8, 32'd8, 17'd2, 1'b0),
            // Every register written with all ones while the frame is still open:
            // everything saturates to its ceiling and the offsets wrap.
            setting(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF),
            plain_item(1'b0, 16'h0000),
            plain_item(1'b1, 16'hFFFF),
            plain_item(1'b0, 16'h0000),
            plain_item(1'b0, 16'h0000),
            // All registers zero, read as one, with the frame open past every limit:
            // all counters wrap at once and the next run closes the frame.
            setting(13'd0, 13'd0, 13'd0, 13'd0, 13'd0),
            plain_item(1'b0, 16'h0000),
            silent_item(1'b1, 16'hA5A5),
            known_run(32'h0000_A5A5, 32'h0000_A5A5, 17'd1, 1'b1),
            silent_item(1'b0, 16'h0000),
            // Longest run the block can produce.
            setting(13'd4096, 13'd16, 13'd3, 13'd2, 13'd1),
            plain_item(1'b1, 16'h5A5A),
            plain_item(1'b0, 16'h0000),
            plain_item(1'b0, 16'h0000)
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_phase(PH_STEADY);
        foreach (directed_steps[i]) begin
            row = directed_steps[i];
            if (row.kind == ROW_SETTING) begin
                settle();
                apply_config(row.cfg_c, row.cfg_s, row.cfg_w, row.cfg_h, row.cfg_d);
            end else begin
                send_item(row, produced);
            end
        end

        // Random part: mostly whole frames under a fresh setting, some cut short by a
        // restart, some continued under a changed setting, and a sprinkling of noise.
        held       = 1'b0;
        rand_items = 0;
        seq_no     = 0;
        while (rand_items < RANDOM_ITEMS) begin
            set_phase(idle_phase_e'((rand_items * 4) / RANDOM_ITEMS));
            if (seq_no % 3 == 0) begin
                settle();
                apply_config(pick_size(), pick_scale(), pick_size(), pick_size(),
                             pick_size());
            end
            seq_no++;

            sc = clamp_field({8'd0, c_scale}, {8'd0, SCALE_MAX});
            frame_runs = sc * sc * clamp_field(c_width, SIZE_MAX)
                       * clamp_field(c_height, SIZE_MAX) * clamp_field(c_depth, SIZE_MAX);
            runs_left = (frame_runs <= 64) ? int'(frame_runs) + $urandom_range(0, 2)
                                           : $urandom_range(4, 40);

            // Now and then carry on with whatever frame is open, or with none.
            if ($urandom_range(0, 9) != 0) begin
                send_item(plain_item(1'b1, 16'($urandom_range(0, 65535))), produced);
                rand_items++;
            end

            while (runs_left > 0 && rand_items < RANDOM_ITEMS) begin
                // One long receiver hold-off while items keep coming, so that the
                // block fills up and has to stall its input.
                if (!held && rand_items >= 150) begin
                    hold_req <= hold_req + 1;
                    held = 1'b1;
                end
                if ($urandom_range(0, 99) < 4) begin
                    row = plain_item(1'b1, 16'($urandom_range(0, 65535)));
                end else begin
                    row = plain_item(1'b0, 16'($urandom_range(0, 65535)));
                    runs_left--;
                end
                send_item(row, produced);
                if (row.restart || produced) begin
                    rand_items++;
                end
            end
        end

        settle();
        $display("Ran %0d items (%0d restarts) under %0d register settings.",
                 items_sent, restarts_sent, settings_written);
        $display("Checked %0d descriptors, %0d of them closing a frame; %0d mismatches.",
                 runs_checked, frames_closed, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
